### src/randstrobe_xor_window_select_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the randstrobe XOR window select block
// Concurrent checks on clk_i with rst_ni as the disable condition.
// ---------------------------------------------------------------------------
`ifndef RANDSTROBE_XOR_WINDOW_SELECT_TOP_MACROS_SVH
`define RANDSTROBE_XOR_WINDOW_SELECT_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge out of reset
`define RSXW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsxw check failed");
// Check that a condition implies another in the same cycle
`define RSXW_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rsxw implication failed");
`else
`define RSXW_ASSERT(lbl, prop)
`define RSXW_ASSERT_IMP(lbl, pre, post)
`endif

`endif

### src/rsxw_pkg.sv
// ---------------------------------------------------------------------------
// rsxw_pkg
// Shared types and constants of the randstrobe XOR window select block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsxw_pkg;

  // Offset and distance width, covers the largest supported window
  localparam int unsigned OFF_W   = 6;
  localparam int unsigned HASH_W  = 64;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_START = 2'd0,
    CFG_WINDOW_END   = 2'd1,
    CFG_SELECT_MAX   = 2'd2
  } rsxw_cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_RUN
  } rsxw_state_e;

  // Input word
  typedef struct packed {
    logic [HASH_W-1:0] hash_value;
    logic              is_last;
  } rsxw_in_t;

  // Output word
  typedef struct packed {
    logic [31:0]       anchor_pos;
    logic [31:0]       partner_pos;
    logic [HASH_W-1:0] partner_hash;
    logic [HASH_W-1:0] link_score;
    logic [HASH_W-1:0] combined_value;
    logic              last_of_run;
  } rsxw_out_t;

  // Search token walking down the cell chain
  typedef struct packed {
    logic              valid;
    logic              fresh;       // no candidate taken yet
    logic              fin;         // final strobe of this input
    logic [OFF_W-1:0]  anchor_dist; // anchor distance behind newest hash
    logic [OFF_W-1:0]  cur_off;     // offset of the cell visited next
    logic [OFF_W-1:0]  best_off;
    logic [HASH_W-1:0] anchor;
    logic [HASH_W-1:0] best_score;
    logic [HASH_W-1:0] best_hash;
  } rsxw_tok_t;

endpackage

`default_nettype wire

### src/rsxw_cell.sv
// ---------------------------------------------------------------------------
// rsxw_cell
// One window cell: holds one hash of the shift line and scores a passing
// search token against it, handing the token to the next cell each cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rsxw_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          shift_i,
  input  wire logic [rsxw_pkg::HASH_W-1:0]   hash_prev_i,
  output logic      [rsxw_pkg::HASH_W-1:0]   hash_o,
  input  wire logic                          sel_max_i,
  input  wire rsxw_pkg::rsxw_tok_t           tok_i,
  output rsxw_pkg::rsxw_tok_t                tok_o
);

  logic [rsxw_pkg::HASH_W-1:0] hash_q;
  logic [rsxw_pkg::HASH_W-1:0] score;
  logic                        better;
  rsxw_pkg::rsxw_tok_t         tok_d;
  rsxw_pkg::rsxw_tok_t         tok_q;

  // Shift the hash line when a new word enters
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      hash_q <= hash_prev_i;
    end
  end

  // Score this cell's hash; earliest candidate keeps ties
  always_comb begin
    score  = tok_i.anchor ^ hash_q;
    better = tok_i.fresh ||
             (sel_max_i ? (score > tok_i.best_score) : (score < tok_i.best_score));
    tok_d         = tok_i;
    tok_d.fresh   = 1'b0;
    tok_d.cur_off = tok_i.cur_off + 1'b1;
    if (better) begin
      tok_d.best_score = score;
      tok_d.best_hash  = hash_q;
      tok_d.best_off   = tok_i.cur_off;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign hash_o = hash_q;
  assign tok_o  = tok_q;

endmodule

`default_nettype wire

### src/randstrobe_xor_window_select_top.sv
// An accepted word that completes a window launches one search token for its anchor, d being
// its anchor distance; a last word launches one per flushed distance d. Each token walks down
// the cell chain to cell 0 and its strobe is then loaded into the output register; a stalled
// strobe word delays the next search. Input is stalled while searches run; a word that
// causes no strobe is taken without a search.
// Reset clears the position counter, fill, sequencer and token valids; the hash line is not cleared.
// ---------------------------------------------------------------------------
// randstrobe_xor_window_select_top
// Order-2 randstrobe linker: picks for each anchor the partner in its window
// with the smallest or largest XOR score using a chain of window cells.
// ---------------------------------------------------------------------------
`default_nettype none
`include "randstrobe_xor_window_select_top_macros.svh"

module randstrobe_xor_window_select_top #(
  parameter int unsigned WINDOW_MAX = 31,
  parameter int unsigned POS_BITS   = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire rsxw_pkg::rsxw_in_t                in_word_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output rsxw_pkg::rsxw_out_t                    out_word_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [rsxw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rsxw_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned DEPTH  = WINDOW_MAX + 1;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned OW     = rsxw_pkg::OFF_W;
  localparam int unsigned HW     = rsxw_pkg::HASH_W;

  // Configuration registers
  logic [rsxw_pkg::CFG_W-1:0] win_start_q, win_end_q;
  logic                       sel_max_q;

  // Sequencer and bookkeeping
  rsxw_pkg::rsxw_state_e state_q, state_d;
  logic [POS_BITS-1:0]   pos_cnt_q, cur_pos_q;
  logic [FILL_W-1:0]     fill_q, fill_new;
  logic [OW-1:0]         cur_d_q, stop_d_q;
  logic                  accept, launch, exit_tok, has_strobe;
  logic [OW-1:0]         ws_raw, we_raw, ws_eff, we_clamp, we_eff, d_first, fill_m1;

  // Cell chain
  logic [HW-1:0]         hw [DEPTH];
  rsxw_pkg::rsxw_tok_t   tok_q [DEPTH];
  logic [DEPTH-1:0]      tok_vld;
  rsxw_pkg::rsxw_tok_t   new_tok;
  logic [OW-1:0]         start_idx;

  // Output register
  logic                  out_valid_q;
  rsxw_pkg::rsxw_out_t   out_word_q;
  logic [POS_BITS-1:0]   anchor_pos_w, partner_pos_w;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= rsxw_pkg::CFG_W'(2);
      win_end_q   <= rsxw_pkg::CFG_W'(10);
      sel_max_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rsxw_pkg::CFG_WINDOW_START: win_start_q <= cfg_data_i;
        rsxw_pkg::CFG_WINDOW_END:   win_end_q   <= cfg_data_i;
        rsxw_pkg::CFG_SELECT_MAX:   sel_max_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the window offsets
  always_comb begin
    ws_raw   = OW'(win_start_q);
    we_raw   = OW'(win_end_q);
    ws_eff   = (ws_raw > OW'(WINDOW_MAX)) ? OW'(WINDOW_MAX) : ws_raw;
    we_clamp = (we_raw > OW'(WINDOW_MAX)) ? OW'(WINDOW_MAX) : we_raw;
    we_eff   = (we_clamp < ws_eff) ? ws_eff : we_clamp;
  end

  // Work out the strobes the accepted word causes
  always_comb begin
    fill_new = (fill_q == FILL_W'(DEPTH)) ? fill_q : fill_q + 1'b1;
    fill_m1  = OW'(fill_new - 1'b1);
    d_first  = (fill_m1 < we_eff) ? fill_m1 : we_eff;
    if (in_word_i.is_last) begin
      has_strobe = d_first > ws_eff;
    end else begin
      has_strobe = fill_new > FILL_W'(we_eff);
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign exit_tok = tok_q[0].valid;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsxw_pkg::ST_IDLE:   if (accept && has_strobe) state_d = rsxw_pkg::ST_LAUNCH;
      rsxw_pkg::ST_LAUNCH: if (launch) state_d = rsxw_pkg::ST_RUN;
      rsxw_pkg::ST_RUN: begin
        if (exit_tok) begin
          state_d = tok_q[0].fin ? rsxw_pkg::ST_IDLE : rsxw_pkg::ST_LAUNCH;
        end
      end
      default: state_d = rsxw_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    launch     = 1'b0;
    unique case (state_q)
      rsxw_pkg::ST_IDLE:   in_stall_o = 1'b0;
      rsxw_pkg::ST_LAUNCH: launch = !out_valid_q || !out_stall_i;
      rsxw_pkg::ST_RUN:    ;
      default: ;
    endcase
  end

  // Hold state, positions, fill and the strobe range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rsxw_pkg::ST_IDLE;
      pos_cnt_q <= '0;
      fill_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        pos_cnt_q <= in_word_i.is_last ? '0 : pos_cnt_q + 1'b1;
        fill_q    <= in_word_i.is_last ? '0 : fill_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_pos_q <= pos_cnt_q;
      cur_d_q   <= in_word_i.is_last ? d_first : we_eff;
      stop_d_q  <= in_word_i.is_last ? ws_eff + 1'b1 : we_eff;
    end else if (exit_tok && !tok_q[0].fin) begin
      cur_d_q <= cur_d_q - 1'b1;
    end
  end

  // Build the token for the next strobe
  always_comb begin
    start_idx           = cur_d_q - ws_eff;
    new_tok             = '0;
    new_tok.valid       = 1'b1;
    new_tok.fresh       = 1'b1;
    new_tok.fin         = cur_d_q == stop_d_q;
    new_tok.anchor_dist = cur_d_q;
    new_tok.cur_off     = ws_eff;
    new_tok.best_off    = ws_eff;
    new_tok.anchor      = hw[cur_d_q[IDX_W-1:0]];
  end

  // Chain of window cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HW-1:0]       prev_hash;
    rsxw_pkg::rsxw_tok_t nbr_tok, tok_in;

    if (i == 0) begin : g_head
      assign prev_hash = in_word_i.hash_value;
    end else begin : g_body
      assign prev_hash = hw[i-1];
    end

    if (i == WINDOW_MAX) begin : g_end
      assign nbr_tok = '0;
    end else begin : g_link
      assign nbr_tok = tok_q[i+1];
    end

    // Inject at the first candidate cell, else take the neighbor's token
    assign tok_in = (launch && start_idx == OW'(i)) ? new_tok : nbr_tok;

    rsxw_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .hash_prev_i(prev_hash),
      .hash_o     (hw[i]),
      .sel_max_i  (sel_max_q),
      .tok_i      (tok_in),
      .tok_o      (tok_q[i])
    );

    assign tok_vld[i] = tok_q[i].valid;
  end

  // Form positions of the finished strobe
  assign anchor_pos_w  = cur_pos_q - POS_BITS'(tok_q[0].anchor_dist);
  assign partner_pos_w = anchor_pos_w + POS_BITS'(tok_q[0].best_off);

  // Load the output word when a token leaves the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exit_tok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_tok) begin
      out_word_q.anchor_pos     <= 32'(anchor_pos_w);
      out_word_q.partner_pos    <= 32'(partner_pos_w);
      out_word_q.partner_hash   <= tok_q[0].best_hash;
      out_word_q.link_score     <= tok_q[0].best_score;
      out_word_q.combined_value <= (tok_q[0].anchor << 1) - tok_q[0].best_hash;
      out_word_q.last_of_run    <= tok_q[0].fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Only one search token in the chain at a time
  `RSXW_ASSERT(a_one_token, $countones(tok_vld) <= 1)
  // A finished strobe never lands on a word still waiting
  `RSXW_ASSERT_IMP(a_out_free, exit_tok, !out_valid_q)
  // No input word enters while a search is in flight
  `RSXW_ASSERT_IMP(a_no_shift_busy, accept, tok_vld == '0)

endmodule

`default_nettype wire
